@@ hw/rtl/hufdec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufdec_pkg
// Shared types and constants of the Huffman tree load and decode unit.
// ----------------------------------------------------------------------------
package hufdec_pkg;

   // default table sizes
   localparam int unsigned MaxNodesDefault   = 512;
   localparam int unsigned StackDepthDefault = 256;

   // preorder node bytes
   localparam logic [7:0] ByteInternal = 8'h49;  // 'I'
   localparam logic [7:0] ByteLeaf     = 8'h4C;  // 'L'

   // item selector
   typedef enum logic [1:0] {
      MODE_TREE  = 2'd0,
      MODE_BIT   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // result codes
   typedef enum logic [2:0] {
      KIND_SYMBOL   = 3'd0,
      KIND_COMPLETE = 3'd1,
      KIND_BAD_NODE = 3'd2,
      KIND_BAD_WALK = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] symbol;
   } result_type;

   // per-cycle memory port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

@@ hw/rtl/hufdec_node_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufdec_node_store
// Node table: one write, one registered read per cycle, plus a one-entry
// deferred write that drains on the next free write slot, with forwarding.
// Entry: [EW-1] leaf flag, [PW-1:0] symbol (leaf) or right child (internal).
// ----------------------------------------------------------------------------
module hufdec_node_store #(
   parameter int unsigned MAX_NODES = hufdec_pkg::MaxNodesDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hufdec_pkg::mem_ctl_type                ctl,
   input  logic [$clog2(MAX_NODES)-1:0]           rd_addr,
   input  logic [$clog2(MAX_NODES)-1:0]           wr_addr,
   input  logic [((($clog2(MAX_NODES)) > 8) ? $clog2(MAX_NODES) : 8):0] wr_data,
   input  logic                                   pend_en,
   input  logic [$clog2(MAX_NODES)-1:0]           pend_addr,
   input  logic [((($clog2(MAX_NODES)) > 8) ? $clog2(MAX_NODES) : 8):0] pend_data,
   output logic [((($clog2(MAX_NODES)) > 8) ? $clog2(MAX_NODES) : 8):0] rd_data
);
   import hufdec_pkg::*;

   localparam int unsigned IW = $clog2(MAX_NODES);
   localparam int unsigned PW = (IW > 8) ? IW : 8;
   localparam int unsigned EW = PW + 1;

   logic [EW-1:0] mem [MAX_NODES];

   logic          pend_valid_ff, pend_valid_in;
   logic [IW-1:0] pend_addr_ff;
   logic [EW-1:0] pend_data_ff;
   logic          drain;
   logic [EW-1:0] rd_q_ff;
   logic          fwd_hit_ff;
   logic [EW-1:0] fwd_data_ff;

   // deferred write goes out when the main port is idle
   assign drain         = pend_valid_ff & ~ctl.wr_en;
   assign pend_valid_in = pend_en | (pend_valid_ff & ctl.wr_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_en) begin
         pend_addr_ff <= pend_addr;
         pend_data_ff <= pend_data;
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end else if (drain) begin
         mem[pend_addr_ff] <= pend_data_ff;
      end
   end

   // registered read, forwarding a drain to the same entry
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_hit_ff  <= drain && (pend_addr_ff == rd_addr);
         fwd_data_ff <= pend_data_ff;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

@@ hw/rtl/hufdec_stack_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufdec_stack_store
// Build stack below the top entry: node index and right-pending flag.
// ----------------------------------------------------------------------------
module hufdec_stack_store #(
   parameter int unsigned MAX_NODES   = hufdec_pkg::MaxNodesDefault,
   parameter int unsigned STACK_DEPTH = hufdec_pkg::StackDepthDefault
) (
   input  logic                              clock,
   input  hufdec_pkg::mem_ctl_type           ctl,
   input  logic [$clog2(STACK_DEPTH)-1:0]    rd_addr,
   input  logic [$clog2(STACK_DEPTH)-1:0]    wr_addr,
   input  logic [$clog2(MAX_NODES):0]        wr_data,
   output logic [$clog2(MAX_NODES):0]        rd_data
);
   import hufdec_pkg::*;

   localparam int unsigned NW = $clog2(MAX_NODES) + 1;

   logic [NW-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/hufdec_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufdec_core
// Tree builder and bit walker. Memory reads go out on the accept cycle from
// the current state; state update and write-back follow when the item fires.
// ----------------------------------------------------------------------------
module hufdec_core #(
   parameter int unsigned MAX_NODES   = hufdec_pkg::MaxNodesDefault,
   parameter int unsigned STACK_DEPTH = hufdec_pkg::StackDepthDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  hufdec_pkg::mode_type                   in_mode,
   input  logic [7:0]                             in_byte,
   input  logic                                   in_bit,
   input  logic                                   fire,
   output logic                                   res_valid,
   output hufdec_pkg::result_type                 res,
   // node table
   output hufdec_pkg::mem_ctl_type                node_ctl,
   output logic [$clog2(MAX_NODES)-1:0]           node_rd_addr,
   output logic [$clog2(MAX_NODES)-1:0]           node_wr_addr,
   output logic [((($clog2(MAX_NODES)) > 8) ? $clog2(MAX_NODES) : 8):0] node_wr_data,
   output logic                                   pend_en,
   output logic [$clog2(MAX_NODES)-1:0]           pend_addr,
   output logic [((($clog2(MAX_NODES)) > 8) ? $clog2(MAX_NODES) : 8):0] pend_data,
   input  logic [((($clog2(MAX_NODES)) > 8) ? $clog2(MAX_NODES) : 8):0] node_rd_data,
   // build stack
   output hufdec_pkg::mem_ctl_type                stk_ctl,
   output logic [$clog2(STACK_DEPTH)-1:0]         stk_rd_addr,
   output logic [$clog2(STACK_DEPTH)-1:0]         stk_wr_addr,
   output logic [$clog2(MAX_NODES):0]             stk_wr_data,
   input  logic [$clog2(MAX_NODES):0]             stk_rd_data
);
   import hufdec_pkg::*;

   localparam int unsigned IW  = $clog2(MAX_NODES);
   localparam int unsigned PW  = (IW > 8) ? IW : 8;
   localparam int unsigned EW  = PW + 1;
   localparam int unsigned NCW = $clog2(MAX_NODES + 1);
   localparam int unsigned SW  = $clog2(STACK_DEPTH);
   localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);

   // item registers
   mode_type      mode_ff;
   logic [7:0]    byte_ff;
   logic [IW-1:0] next_addr_ff;

   // control state
   logic [NCW-1:0] node_count_ff, node_count_in;
   logic [SCW-1:0] stack_top_ff, stack_top_in;
   logic           expect_ff, expect_in;
   logic           ready_ff, ready_in;
   logic [IW-1:0]  walk_pos_ff, walk_pos_in;

   // cached entries and top of stack
   logic [EW-1:0]  cur_entry_ff, cur_entry_in;
   logic [EW-1:0]  root_entry_ff, root_entry_in;
   logic [IW-1:0]  top_node_ff, top_node_in;
   logic           top_right_ff, top_right_in;

   logic [IW-1:0]  idx;
   logic [IW-1:0]  next_addr;
   logic [SCW-1:0] below_top;
   logic [SCW-1:0] top_slot;
   logic           full_nodes;
   logic           full_stack;
   logic           has_top;
   logic [EW-1:0]  leaf_entry;
   logic [EW-1:0]  link_entry;
   logic           node_wr_en;
   logic           stk_wr_en;

   assign idx        = node_count_ff[IW-1:0];
   assign full_nodes = node_count_ff >= NCW'(MAX_NODES);
   assign full_stack = stack_top_ff >= SCW'(STACK_DEPTH);
   assign has_top    = stack_top_ff != '0;
   assign leaf_entry = {1'b1, PW'(byte_ff)};
   assign link_entry = {1'b0, PW'(idx)};
   assign below_top  = stack_top_ff - SCW'(2);
   assign top_slot   = stack_top_ff - SCW'(1);

   // child to fetch for a code bit: left is always the next node in preorder
   assign next_addr = in_bit ? cur_entry_ff[IW-1:0] : (walk_pos_ff + IW'(1));

   // read side, issued on accept
   assign node_ctl.rd_en = start;
   assign node_ctl.wr_en = node_wr_en;
   assign node_rd_addr   = next_addr;
   assign stk_ctl.rd_en  = start;
   assign stk_ctl.wr_en  = stk_wr_en;
   assign stk_rd_addr    = below_top[SW-1:0];
   assign stk_wr_addr    = top_slot[SW-1:0];
   assign stk_wr_data    = {top_node_ff, 1'b1};
   assign pend_addr      = top_node_ff;
   assign pend_data      = link_entry;

   always_ff @(posedge clock) begin
      if (start) begin
         mode_ff      <= in_mode;
         byte_ff      <= in_byte;
         next_addr_ff <= next_addr;
      end
   end

   // next state and write-back
   always_comb begin
      node_count_in = node_count_ff;
      stack_top_in  = stack_top_ff;
      expect_in     = expect_ff;
      ready_in      = ready_ff;
      walk_pos_in   = walk_pos_ff;
      cur_entry_in  = cur_entry_ff;
      root_entry_in = root_entry_ff;
      top_node_in   = top_node_ff;
      top_right_in  = top_right_ff;
      node_wr_en    = 1'b0;
      node_wr_addr  = idx;
      node_wr_data  = leaf_entry;
      pend_en       = 1'b0;
      stk_wr_en     = 1'b0;
      res_valid     = 1'b0;
      res.kind      = KIND_SYMBOL;
      res.symbol    = 8'd0;

      if (fire) begin
         case (mode_ff)
            MODE_CLEAR: begin
               stack_top_in  = '0;
               node_count_in = '0;
               expect_in     = 1'b0;
               ready_in      = 1'b0;
               walk_pos_in   = '0;
            end

            MODE_TREE: begin
               if (!ready_ff) begin
                  if (expect_ff) begin
                     // symbol byte: place leaf, hang it below the stack top
                     expect_in     = 1'b0;
                     node_count_in = node_count_ff + NCW'(1);
                     node_wr_en    = 1'b1;
                     if (idx == '0) begin
                        root_entry_in = leaf_entry;
                     end
                     if (has_top && !top_right_ff) begin
                        top_right_in = 1'b1;
                     end else begin
                        if (has_top) begin
                           // right link to parent goes out as the deferred write
                           pend_en      = 1'b1;
                           stack_top_in = stack_top_ff - SCW'(1);
                           top_node_in  = stk_rd_data[IW:1];
                           top_right_in = stk_rd_data[0];
                           if (top_node_ff == '0) begin
                              root_entry_in = link_entry;
                           end
                        end
                        if (stack_top_ff <= SCW'(1)) begin
                           ready_in     = 1'b1;
                           walk_pos_in  = '0;
                           cur_entry_in = root_entry_in;
                           res_valid    = 1'b1;
                           res.kind     = KIND_COMPLETE;
                        end
                     end
                  end else if (byte_ff == ByteLeaf) begin
                     if (full_nodes) begin
                        stack_top_in  = '0;
                        node_count_in = '0;
                        expect_in     = 1'b0;
                        walk_pos_in   = '0;
                        res_valid     = 1'b1;
                        res.kind      = KIND_OVERFLOW;
                     end else begin
                        expect_in = 1'b1;
                     end
                  end else if (byte_ff == ByteInternal) begin
                     if (full_nodes || full_stack) begin
                        stack_top_in  = '0;
                        node_count_in = '0;
                        expect_in     = 1'b0;
                        walk_pos_in   = '0;
                        res_valid     = 1'b1;
                        res.kind      = KIND_OVERFLOW;
                     end else begin
                        // new internal node becomes the stack top
                        node_count_in = node_count_ff + NCW'(1);
                        top_node_in   = idx;
                        top_right_in  = 1'b0;
                        if (!has_top) begin
                           stack_top_in = SCW'(1);
                        end else if (!top_right_ff) begin
                           stk_wr_en    = 1'b1;
                           stack_top_in = stack_top_ff + SCW'(1);
                        end else begin
                           // right child: pop parent, push new node in its slot
                           node_wr_en   = 1'b1;
                           node_wr_addr = top_node_ff;
                           node_wr_data = link_entry;
                           if (top_node_ff == '0) begin
                              root_entry_in = link_entry;
                           end
                        end
                     end
                  end else begin
                     stack_top_in  = '0;
                     node_count_in = '0;
                     expect_in     = 1'b0;
                     walk_pos_in   = '0;
                     res_valid     = 1'b1;
                     res.kind      = KIND_BAD_NODE;
                  end
               end
            end

            MODE_BIT: begin
               res_valid = 1'b1;
               if (!ready_ff || cur_entry_ff[EW-1]) begin
                  walk_pos_in  = '0;
                  cur_entry_in = root_entry_ff;
                  res.kind     = KIND_BAD_WALK;
               end else if (node_rd_data[EW-1]) begin
                  walk_pos_in  = '0;
                  cur_entry_in = root_entry_ff;
                  res.kind     = KIND_SYMBOL;
                  res.symbol   = node_rd_data[7:0];
               end else begin
                  res_valid    = 1'b0;
                  walk_pos_in  = next_addr_ff;
                  cur_entry_in = node_rd_data;
               end
            end

            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         stack_top_ff  <= '0;
         expect_ff     <= 1'b0;
         ready_ff      <= 1'b0;
         walk_pos_ff   <= '0;
      end else begin
         node_count_ff <= node_count_in;
         stack_top_ff  <= stack_top_in;
         expect_ff     <= expect_in;
         ready_ff      <= ready_in;
         walk_pos_ff   <= walk_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_entry_ff  <= cur_entry_in;
      root_entry_ff <= root_entry_in;
      top_node_ff   <= top_node_in;
      top_right_ff  <= top_right_in;
   end

endmodule

@@ hw/rtl/huffman_tree_load_and_decode_unit.sv @@
`timescale 1ns / 1ps
// Flow: one beat in flight; a new beat is accepted only after the last one fires.
//   Each beat issues its registered node/stack read on acceptance, used when it fires.
// Results: a result beat is registered when its item fires, which waits for
//   the result slot to be free; a held result beat stalls the input.
// Reset: synchronous; clears counters, flags and walk position. The node table
//   and stack are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_unit
// Loads a preorder Huffman tree and decodes code bits against it.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_unit #(
   parameter int unsigned MAX_NODES   = hufdec_pkg::MaxNodesDefault,
   parameter int unsigned STACK_DEPTH = hufdec_pkg::StackDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tree_byte, [8] code_bit, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] symbol
   output logic [2:0]  rsp_tuser    // [2:0] result_kind
);
   import hufdec_pkg::*;

   localparam int unsigned IW = $clog2(MAX_NODES);
   localparam int unsigned PW = (IW > 8) ? IW : 8;
   localparam int unsigned EW = PW + 1;
   localparam int unsigned SW = $clog2(STACK_DEPTH);

   logic          busy_ff, busy_in;
   logic          start;
   logic          fire;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff;
   logic          res_valid;
   result_type    res;

   mem_ctl_type   node_ctl;
   logic [IW-1:0] node_rd_addr;
   logic [IW-1:0] node_wr_addr;
   logic [EW-1:0] node_wr_data;
   logic          pend_en;
   logic [IW-1:0] pend_addr;
   logic [EW-1:0] pend_data;
   logic [EW-1:0] node_rd_data;
   mem_ctl_type   stk_ctl;
   logic [SW-1:0] stk_rd_addr;
   logic [SW-1:0] stk_wr_addr;
   logic [IW:0]   stk_wr_data;
   logic [IW:0]   stk_rd_data;

   // handshake: one item in flight, result slot must be free to retire it
   assign req_tready   = ~busy_ff;
   assign start        = req_tvalid & ~busy_ff;
   assign fire         = busy_ff & (~rsp_valid_ff | rsp_tready);
   assign busy_in      = start | (busy_ff & ~fire);
   assign rsp_valid_in = (fire & res_valid) | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.symbol;
   assign rsp_tuser  = rsp_ff.kind;

   hufdec_core #(
      .MAX_NODES   (MAX_NODES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .in_mode      (mode_type'(req_tuser)),
      .in_byte      (req_tdata[7:0]),
      .in_bit       (req_tdata[8]),
      .fire         (fire),
      .res_valid    (res_valid),
      .res          (res),
      .node_ctl     (node_ctl),
      .node_rd_addr (node_rd_addr),
      .node_wr_addr (node_wr_addr),
      .node_wr_data (node_wr_data),
      .pend_en      (pend_en),
      .pend_addr    (pend_addr),
      .pend_data    (pend_data),
      .node_rd_data (node_rd_data),
      .stk_ctl      (stk_ctl),
      .stk_rd_addr  (stk_rd_addr),
      .stk_wr_addr  (stk_wr_addr),
      .stk_wr_data  (stk_wr_data),
      .stk_rd_data  (stk_rd_data)
   );

   hufdec_node_store #(
      .MAX_NODES (MAX_NODES)
   ) u_node_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (node_ctl),
      .rd_addr   (node_rd_addr),
      .wr_addr   (node_wr_addr),
      .wr_data   (node_wr_data),
      .pend_en   (pend_en),
      .pend_addr (pend_addr),
      .pend_data (pend_data),
      .rd_data   (node_rd_data)
   );

   hufdec_stack_store #(
      .MAX_NODES   (MAX_NODES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack_store (
      .clock   (clock),
      .ctl     (stk_ctl),
      .rd_addr (stk_rd_addr),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_data (stk_rd_data)
   );

endmodule

@@ bench/huffman_tree_load_and_decode_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_unit_tb
// Self-checking bench for the Huffman tree loader and bit-serial decoder.
// A directed table covers the reset state, bad node bytes, the lone-leaf
// tree, ignored bytes and clear. Random preorder trees with random code bits
// follow, mixed with broken trees, noise and both kinds of overflow. Each
// accepted beat runs through a local tree model, and every result beat is
// compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_unit_tb;
   import hufdec_pkg::*;

   localparam int unsigned NODE_LIMIT  = MaxNodesDefault;
   localparam int unsigned STACK_LIMIT = StackDepthDefault;
   localparam int unsigned ITEMS       = 1250;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned LIMIT       = 400000;

   // one row of the directed table; typed rows carry their own result
   typedef struct packed {
      mode_type   mode;
      logic [7:0] tbyte;
      logic       cbit;
      logic       typed;
      kind_type   kind;
      logic [7:0] sym;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [7:0] tree_byte, [8] code_bit, rest zero
   logic [1:0]  req_tuser;    // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;    // [7:0] symbol
   logic [2:0]  rsp_tuser;    // [2:0] result_kind

   // tree model state
   bit          node_is_leaf [NODE_LIMIT];
   logic [7:0]  node_sym     [NODE_LIMIT];
   int unsigned node_lt      [NODE_LIMIT];
   int unsigned node_rt      [NODE_LIMIT];
   bit          node_lt_ok   [NODE_LIMIT];
   bit          node_rt_ok   [NODE_LIMIT];
   int unsigned pend_node    [STACK_LIMIT];
   bit          pend_right   [STACK_LIMIT];
   int unsigned pend_depth;
   int unsigned node_total;
   bit          want_symbol;
   bit          tree_done;
   int unsigned walk_at;

   result_type   pending_results [$];
   step_row_type dir_steps [22];
   int unsigned  beats_counted;
   int unsigned  errors;
   int unsigned  cycle_count;
   bit           calm;
   bit           hold_req;

   huffman_tree_load_and_decode_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // random field values
   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // ---------------------------------------------------------------- model
   function automatic void wipe_tree();
      pend_depth  = 0;
      node_total  = 0;
      want_symbol = 1'b0;
      tree_done   = 1'b0;
      walk_at     = 0;
   endfunction

   // allocate a node and hang it under the internal node on top of the stack
   function automatic void attach_node(input bit leaf, input logic [7:0] sym);
      int unsigned idx;
      int unsigned top;
      idx = node_total;
      node_is_leaf[idx] = leaf;
      node_sym[idx]     = sym;
      node_lt_ok[idx]   = 1'b0;
      node_rt_ok[idx]   = 1'b0;
      node_total        = idx + 1;
      if (pend_depth > 0) begin
         top = pend_depth - 1;
         if (!pend_right[top]) begin
            node_lt[pend_node[top]]    = idx;
            node_lt_ok[pend_node[top]] = 1'b1;
            pend_right[top]            = 1'b1;
         end else begin
            node_rt[pend_node[top]]    = idx;
            node_rt_ok[pend_node[top]] = 1'b1;
            pend_depth                 = top;
         end
      end
   endfunction

   // advance the model by one beat; returns 1 when a result beat is due
   function automatic bit forecast(input mode_type m, input logic [7:0] b, input logic c,
                                   output result_type r);
      bit          hit;
      bit          ok;
      int unsigned nxt;
      hit      = 1'b0;
      r.kind   = KIND_SYMBOL;
      r.symbol = 8'h00;
      case (m)
         MODE_CLEAR: begin
            wipe_tree();
         end
         MODE_TREE: begin
            if (tree_done) begin
               // tree bytes are dropped until a clear
            end else if (want_symbol) begin
               want_symbol = 1'b0;
               attach_node(1'b1, b);
               if (pend_depth == 0) begin
                  tree_done = 1'b1;
                  walk_at   = 0;
                  r.kind    = KIND_COMPLETE;
                  hit       = 1'b1;
               end
            end else if (b == ByteLeaf) begin
               if (node_total >= NODE_LIMIT) begin
                  wipe_tree();
                  r.kind = KIND_OVERFLOW;
                  hit    = 1'b1;
               end else begin
                  want_symbol = 1'b1;
               end
            end else if (b == ByteInternal) begin
               if (node_total >= NODE_LIMIT || pend_depth >= STACK_LIMIT) begin
                  wipe_tree();
                  r.kind = KIND_OVERFLOW;
                  hit    = 1'b1;
               end else begin
                  nxt = node_total;
                  attach_node(1'b0, 8'h00);
                  pend_node[pend_depth]  = nxt;
                  pend_right[pend_depth] = 1'b0;
                  pend_depth++;
               end
            end else begin
               wipe_tree();
               r.kind = KIND_BAD_NODE;
               hit    = 1'b1;
            end
         end
         MODE_BIT: begin
            hit = 1'b1;
            if (!tree_done || walk_at >= node_total || node_is_leaf[walk_at]) begin
               walk_at = 0;
               r.kind  = KIND_BAD_WALK;
            end else begin
               nxt = c ? node_rt[walk_at] : node_lt[walk_at];
               ok  = c ? node_rt_ok[walk_at] : node_lt_ok[walk_at];
               if (!ok || nxt >= node_total) begin
                  walk_at = 0;
                  r.kind  = KIND_BAD_WALK;
               end else if (node_is_leaf[nxt]) begin
                  walk_at  = 0;
                  r.symbol = node_sym[nxt];
               end else begin
                  walk_at = nxt;
                  hit     = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      return hit;
   endfunction

   // ---------------------------------------------------------------- sender
   task automatic quiet_input();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // offer one beat, wait for acceptance, then record what it should cause
   task automatic send_beat(input mode_type m, input logic [7:0] b, input logic c,
                            input bit typed = 1'b0, input result_type want = '0);
      result_type r;
      bit         due;
      if (!calm && $urandom_range(0, 3) == 0) begin
         quiet_input();
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, c, b};
      req_tuser  <= m;
      do @(posedge clock); while (!req_tready);
      due = forecast(m, b, c, r);
      if (typed) begin
         r   = want;
         due = 1'b1;
      end
      if (due) pending_results.insert(pending_results.size(), r);
      beats_counted++;
   endtask

   // send a random preorder tree, stopping after cut bytes
   task automatic send_tree(input int unsigned inner_max, input int unsigned cut);
      int unsigned open_slots;
      int unsigned inners;
      int unsigned sent;
      open_slots = 1;
      inners     = 0;
      sent       = 0;
      while (open_slots > 0 && sent < cut) begin
         if (inners < inner_max && $urandom_range(0, 1)) begin
            send_beat(MODE_TREE, ByteInternal, rand_bit());
            inners++;
            open_slots++;
            sent++;
         end else begin
            send_beat(MODE_TREE, ByteLeaf, rand_bit());
            sent++;
            if (sent < cut) begin
               send_beat(MODE_TREE, rand_byte(), rand_bit());
               sent++;
            end
            open_slots--;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin
      bit held;
      held = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            // long hold-off so the block backs up and stalls its input
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checker
   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t ns: mismatch on %s: got %0h, predicted %0h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report("result beat with nothing pending, kind", 8'(rsp_tuser), 8'h00);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser != want.kind) report("result kind", 8'(rsp_tuser), 8'(want.kind));
            if (rsp_tdata != want.symbol) report("symbol", rsp_tdata, want.symbol);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      bit         did_stack;
      bit         did_nodes;
      bit         did_hold;
      bit         did_drain;
      int unsigned pick;
      logic [7:0] odd;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_NONE;
      did_stack  = 1'b0;
      did_nodes  = 1'b0;
      did_hold   = 1'b0;
      did_drain  = 1'b0;
      wipe_tree();

      dir_steps = '{
         '{MODE_BIT,   8'h00,        1'b0, 1'b1, KIND_BAD_WALK, 8'h00}, // no tree yet
         '{MODE_TREE,  8'hFF,        1'b0, 1'b1, KIND_BAD_NODE, 8'h00}, // unknown node byte
         '{MODE_TREE,  ByteLeaf,     1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  8'h00,        1'b0, 1'b1, KIND_COMPLETE, 8'h00}, // lone leaf root
         '{MODE_TREE,  ByteInternal, 1'b0, 1'b0, KIND_SYMBOL,   8'h00}, // ignored, tree done
         '{MODE_BIT,   8'h00,        1'b1, 1'b1, KIND_BAD_WALK, 8'h00}, // walk off leaf root
         '{MODE_CLEAR, 8'h00,        1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  ByteInternal, 1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  ByteLeaf,     1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  8'h00,        1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  ByteLeaf,     1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  8'hFF,        1'b0, 1'b1, KIND_COMPLETE, 8'h00},
         '{MODE_BIT,   8'h00,        1'b0, 1'b1, KIND_SYMBOL,   8'h00},
         '{MODE_BIT,   8'h00,        1'b1, 1'b1, KIND_SYMBOL,   8'hFF},
         '{MODE_NONE,  8'hFF,        1'b1, 1'b0, KIND_SYMBOL,   8'h00}, // no-op mode
         '{MODE_CLEAR, 8'hFF,        1'b1, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  ByteInternal, 1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  8'h00,        1'b0, 1'b1, KIND_BAD_NODE, 8'h00}, // drops partial tree
         '{MODE_TREE,  ByteLeaf,     1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_TREE,  ByteLeaf,     1'b0, 1'b1, KIND_COMPLETE, 8'h00}, // 'L' as a symbol
         '{MODE_BIT,   8'h00,        1'b0, 1'b0, KIND_SYMBOL,   8'h00},
         '{MODE_CLEAR, 8'h00,        1'b0, 1'b0, KIND_SYMBOL,   8'h00}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int k = 0; k < $size(dir_steps); k++) begin
         send_beat(dir_steps[k].mode, dir_steps[k].tbyte, dir_steps[k].cbit,
                   dir_steps[k].typed, '{kind: dir_steps[k].kind, symbol: dir_steps[k].sym});
      end

      // random sequences
      while (beats_counted < ITEMS) begin
         calm = (beats_counted + 150 >= ITEMS);

         if (!did_stack && beats_counted >= 60) begin
            // one internal node more than the stack holds
            did_stack = 1'b1;
            send_beat(MODE_CLEAR, rand_byte(), rand_bit());
            repeat (STACK_LIMIT + 1) send_beat(MODE_TREE, ByteInternal, 1'b0);
            send_beat(MODE_BIT, 8'h00, rand_bit());
         end

         if (!did_drain && beats_counted >= 200) begin
            did_drain = 1'b1;
            quiet_input();
            while (pending_results.size() != 0) @(posedge clock);
         end

         if (!did_hold && beats_counted >= 250) begin
            did_hold = 1'b1;
            hold_req = 1'b1;
         end

         if (!did_nodes && beats_counted >= 300) begin
            // right-leaning chain fills the node table with the stack at depth one
            did_nodes = 1'b1;
            send_beat(MODE_CLEAR, 8'h00, 1'b0);
            repeat (NODE_LIMIT / 2) begin
               send_beat(MODE_TREE, ByteInternal, 1'b0);
               send_beat(MODE_TREE, ByteLeaf, 1'b0);
               send_beat(MODE_TREE, rand_byte(), 1'b0);
            end
            send_beat(MODE_TREE, $urandom_range(0, 1) ? ByteLeaf : ByteInternal, 1'b0);
            send_beat(MODE_BIT, 8'h00, rand_bit());
         end

         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // well-formed tree, then a run of code bits
            if ($urandom_range(0, 3) != 0) send_beat(MODE_CLEAR, rand_byte(), rand_bit());
            send_tree(($urandom_range(0, 9) == 0) ? $urandom_range(16, 100)
                                                  : $urandom_range(0, 15), 32'hFFFF_FFFF);
            repeat ($urandom_range(8, 48)) begin
               if ($urandom_range(0, 19) == 0)
                  send_beat(MODE_TREE, rand_byte(), rand_bit());
               else
                  send_beat(MODE_BIT, rand_byte(), rand_bit());
            end
         end else if (pick < 85) begin
            // partial tree cut off by a bad byte, a stray bit or a no-op
            send_beat(MODE_CLEAR, 8'h00, 1'b0);
            send_tree($urandom_range(1, 10), $urandom_range(1, 12));
            case ($urandom_range(0, 2))
               0: begin
                  do odd = rand_byte();
                  while (odd == ByteInternal || odd == ByteLeaf);
                  send_beat(MODE_TREE, odd, rand_bit());
               end
               1: send_beat(MODE_BIT, rand_byte(), rand_bit());
               default: send_beat(MODE_NONE, rand_byte(), rand_bit());
            endcase
            repeat ($urandom_range(0, 4))
               send_beat(MODE_BIT, rand_byte(), rand_bit());
         end else begin
            // unstructured noise
            repeat ($urandom_range(3, 10))
               send_beat(mode_type'($urandom_range(0, 3)), rand_byte(), rand_bit());
         end
      end

      // drain and finish
      quiet_input();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/hufdec_pkg.sv
hw/rtl/hufdec_node_store.sv
hw/rtl/hufdec_stack_store.sv
hw/rtl/hufdec_core.sv
hw/rtl/huffman_tree_load_and_decode_unit.sv
bench/huffman_tree_load_and_decode_unit_tb.sv
